// ===== rtl/ptt_pkg.sv =====
// Package for the periodic and one-shot timer table.
// Holds the item kinds, status codes, controller states and command/status structs.
package ptt_pkg;

    localparam int SlotCountDefault      = 8;
    localparam int MaxCheckpointsDefault = 64;
    localparam int TimeW                 = 32;
    localparam int MaskW                 = 8;
    localparam int SlotIdxW              = 3;

    typedef enum logic [1:0] {
        KIND_ONESHOT  = 2'd0,
        KIND_PERIODIC = 2'd1,
        KIND_ADVANCE  = 2'd2,
        KIND_UNUSED   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_LIMIT = 2'd2,
        ST_RSVD  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MINSCAN,
        S_VISIT,
        S_EMIT,
        S_SCHED
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;     // register the accepted input beat
        logic min_clear;   // start the minimum-period search
        logic min_step;    // examine one slot for the minimum period
        logic visit_clear; // start a checkpoint visit
        logic visit_step;  // evaluate one slot at the current checkpoint
        logic sched;       // store a schedule item into the table
        logic out_load;    // load the output register
        logic out_last;
        logic [1:0] out_status;
        logic advance_t;   // move the checkpoint time forward
        logic finish;      // current time takes the target
        logic set_time;    // backward advance: current time takes the target
    } ptt_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] kind;
        logic       scan_done;
        logic       t_reached;
        logic       backward;
        logic       table_full;
    } ptt_sts_t;

endpackage

// ===== rtl/ptt_in_if.sv =====
// Input channel interface of the timer table.
// Depends on ptt_pkg for the time width.
interface ptt_in_if
    import ptt_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [1:0]       kind;
    logic [TimeW-1:0] start_time;
    logic [TimeW-1:0] period;
    logic [TimeW-1:0] end_time;
    logic [TimeW-1:0] new_time;

    modport source (output valid, kind, start_time, period, end_time, new_time, input ready);
    modport sink   (input valid, kind, start_time, period, end_time, new_time, output ready);
endinterface

// ===== rtl/ptt_out_if.sv =====
// Result channel interface of the timer table.
// Depends on ptt_pkg for field widths.
interface ptt_out_if
    import ptt_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [MaskW-1:0]    fired_mask;
    logic [TimeW-1:0]    at_time;
    logic [SlotIdxW-1:0] slot_index;
    logic [1:0]          status;
    logic                last;

    modport source (output valid, fired_mask, at_time, slot_index, status, last, input ready);
    modport sink   (input valid, fired_mask, at_time, slot_index, status, last, output ready);
endinterface

// ===== rtl/ptt_ctrl.sv =====
// Controller state machine of the timer table.
// Depends on ptt_pkg; drives the datapath through ptt_cmd_t.
module ptt_ctrl
    import ptt_pkg::*;
#(
    parameter int MAX_CHECKPOINTS = MaxCheckpointsDefault
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  logic     out_busy,
    input  ptt_sts_t sts,
    output ptt_cmd_t cmd
);
    localparam int CntW = $clog2(MAX_CHECKPOINTS + 1);

    state_t          state_reg, state_next;
    logic [CntW-1:0] cnt_reg, cnt_next;

    // State and checkpoint count registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    state_next    = S_MINSCAN;
                    cmd.min_clear = 1'b1;
                    cnt_next      = '0;
                end
            end
            S_MINSCAN:
            begin
                // Decode the captured kind; schedules skip the scan.
                if (sts.kind == KIND_ONESHOT || sts.kind == KIND_PERIODIC)
                    state_next = S_SCHED;
                else if (sts.kind != KIND_ADVANCE)
                    state_next = S_IDLE;
                else if (sts.backward)
                begin
                    cmd.set_time = 1'b1;
                    state_next   = S_IDLE;
                end
                else
                begin
                    cmd.min_step = 1'b1;
                    if (sts.scan_done)
                    begin
                        cmd.visit_clear = 1'b1;
                        state_next      = S_VISIT;
                    end
                end
            end
            S_SCHED:
            begin
                if (!out_busy)
                begin
                    cmd.sched      = !sts.table_full;
                    cmd.out_load   = 1'b1;
                    cmd.out_last   = 1'b1;
                    cmd.out_status = sts.table_full ? ST_FULL : ST_OK;
                    state_next     = S_IDLE;
                end
            end
            S_VISIT:
            begin
                cmd.visit_step = 1'b1;
                if (sts.scan_done)
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_busy)
                begin
                    cmd.out_load = 1'b1;
                    if (sts.t_reached)
                    begin
                        cmd.out_last = 1'b1;
                        cmd.finish   = 1'b1;
                        state_next   = S_IDLE;
                    end
                    else if (cnt_reg == CntW'(MAX_CHECKPOINTS - 1))
                    begin
                        cmd.out_last   = 1'b1;
                        cmd.out_status = ST_LIMIT;
                        cmd.finish     = 1'b1;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        cmd.advance_t   = 1'b1;
                        cmd.visit_clear = 1'b1;
                        cnt_next        = cnt_reg + 1'b1;
                        state_next      = S_VISIT;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule

// ===== rtl/ptt_dp.sv =====
// Datapath of the timer table: slot registers, scan unit and output register.
// Depends on ptt_pkg for field widths.
module ptt_dp
    import ptt_pkg::*;
#(
    parameter int SLOT_COUNT = SlotCountDefault
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [1:0]          kind,
    input  logic [TimeW-1:0]    start_time,
    input  logic [TimeW-1:0]    period,
    input  logic [TimeW-1:0]    end_time,
    input  logic [TimeW-1:0]    new_time,
    input  ptt_cmd_t            cmd,
    output ptt_sts_t            sts,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [MaskW-1:0]    fired_mask,
    output logic [TimeW-1:0]    at_time,
    output logic [SlotIdxW-1:0] slot_index,
    output logic [1:0]          status,
    output logic                last,
    output logic                out_busy
);
    localparam int IdxW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    // Captured input beat.
    logic [1:0]       kind_reg;
    logic [TimeW-1:0] start_reg, period_reg, end_reg, target_reg;

    // Slot table.
    logic [SLOT_COUNT-1:0] used_reg, used_next;
    logic [SLOT_COUNT-1:0] oneshot_reg;
    logic [TimeW-1:0]      sstart_reg [SLOT_COUNT];
    logic [TimeW-1:0]      speriod_reg[SLOT_COUNT];
    logic [TimeW-1:0]      send_reg   [SLOT_COUNT];
    logic [TimeW-1:0]      snext_reg  [SLOT_COUNT];

    logic [TimeW-1:0]      cur_time_reg, t_reg, step_reg;
    logic [IdxW-1:0]       idx_reg;
    logic [SLOT_COUNT-1:0] mask_reg;

    // Output register.
    logic                  ovalid_reg;
    logic [MaskW-1:0]      omask_reg;
    logic [TimeW-1:0]      otime_reg;
    logic [SlotIdxW-1:0]   oslot_reg;
    logic [1:0]            ostatus_reg;
    logic                  olast_reg;

    // Lowest free slot.
    logic [IdxW-1:0] free_idx;
    logic            full;
    always_comb
    begin
        free_idx = '0;
        full     = 1'b1;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_idx = IdxW'(i);
                full     = 1'b0;
            end
        end
    end

    // One slot per cycle: values of the slot under the scan index.
    logic [TimeW-1:0] c_start, c_period, c_end, c_next;
    logic [TimeW:0]   nx_sum;
    logic             c_used, c_one, p_fire, o_fire;
    assign c_used   = used_reg[idx_reg];
    assign c_one    = oneshot_reg[idx_reg];
    assign c_start  = sstart_reg[idx_reg];
    assign c_period = speriod_reg[idx_reg];
    assign c_end    = send_reg[idx_reg];
    assign c_next   = snext_reg[idx_reg];
    assign nx_sum   = {1'b0, c_next} + {1'b0, c_period};
    assign o_fire   = c_used && c_one && (t_reg >= c_start);
    assign p_fire   = c_used && !c_one && (t_reg > c_start) && (t_reg <= c_end)
                      && (t_reg >= c_next);

    // Next checkpoint time, clamped to the target.
    logic [TimeW:0] t_sum;
    assign t_sum = {1'b0, t_reg} + {1'b0, step_reg};

    assign sts.kind       = kind_reg;
    assign sts.scan_done  = (idx_reg == IdxW'(SLOT_COUNT - 1));
    assign sts.t_reached  = (t_reg >= target_reg);
    assign sts.backward   = (target_reg < cur_time_reg);
    assign sts.table_full = full;

    // Slot valid bits.
    always_comb
    begin
        used_next = used_reg;
        if (cmd.sched)
            used_next[free_idx] = 1'b1;
        if (cmd.visit_step && c_used)
        begin
            if (o_fire || (p_fire && nx_sum[TimeW]) ||
                (!c_one && !p_fire && t_reg > c_end))
                used_next[idx_reg] = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg     <= '0;
            cur_time_reg <= '0;
            idx_reg      <= '0;
            ovalid_reg   <= 1'b0;
        end
        else
        begin
            used_reg <= used_next;
            if (cmd.set_time || cmd.finish)
                cur_time_reg <= target_reg;
            if (cmd.min_clear || cmd.visit_clear || sts.scan_done)
                idx_reg <= '0;
            else if (cmd.min_step || cmd.visit_step)
                idx_reg <= idx_reg + 1'b1;
            if (cmd.out_load)
                ovalid_reg <= 1'b1;
            else if (out_ready)
                ovalid_reg <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg   <= kind;
            start_reg  <= start_time;
            period_reg <= period;
            end_reg    <= end_time;
            target_reg <= new_time;
        end
        if (cmd.min_clear)
        begin
            step_reg <= '0;
            t_reg    <= cur_time_reg;
        end
        else if (cmd.min_step)
        begin
            if (c_used && !c_one && c_period != '0 &&
                (step_reg == '0 || c_period < step_reg))
                step_reg <= c_period;
            else if (sts.scan_done && step_reg == '0)
                step_reg <= TimeW'(1);
        end
        if (cmd.advance_t)
            t_reg <= (t_sum > {1'b0, target_reg}) ? target_reg : t_sum[TimeW-1:0];
        if (cmd.visit_clear)
            mask_reg <= '0;
        else if (cmd.visit_step)
            mask_reg[idx_reg] <= o_fire || p_fire;
        if (cmd.visit_step && p_fire && !nx_sum[TimeW])
            snext_reg[idx_reg] <= nx_sum[TimeW-1:0];
        if (cmd.sched)
        begin
            sstart_reg[free_idx] <= start_reg;
            snext_reg[free_idx]  <= start_reg;
            if (kind_reg == KIND_ONESHOT || period_reg == '0)
            begin
                oneshot_reg[free_idx] <= 1'b1;
                speriod_reg[free_idx] <= '0;
                send_reg[free_idx]    <= '0;
            end
            else
            begin
                oneshot_reg[free_idx] <= 1'b0;
                speriod_reg[free_idx] <= period_reg;
                send_reg[free_idx]    <= end_reg;
            end
        end
        if (cmd.out_load)
        begin
            olast_reg   <= cmd.out_last;
            ostatus_reg <= cmd.out_status;
            if (cmd.sched || kind_reg != KIND_ADVANCE)
            begin
                omask_reg <= '0;
                otime_reg <= cur_time_reg;
                oslot_reg <= full ? '0 : SlotIdxW'(free_idx);
            end
            else
            begin
                for (int b = 0; b < MaskW; b++)
                    omask_reg[b] <= (b < SLOT_COUNT) ? mask_reg[b % SLOT_COUNT] : 1'b0;
                otime_reg <= t_reg;
                oslot_reg <= '0;
            end
        end
    end

    assign out_busy   = ovalid_reg && !out_ready;
    assign out_valid  = ovalid_reg;
    assign fired_mask = omask_reg;
    assign at_time    = otime_reg;
    assign slot_index = oslot_reg;
    assign status     = ostatus_reg;
    assign last       = olast_reg;
endmodule

// ===== rtl/periodic_and_oneshot_timer_table.sv =====
// Channel  Dir  Beat
// in       in   kind, start_time, period, end_time, new_time
// out      out  fired_mask, at_time, slot_index, status, last
//
// A schedule item passes from idle through the scan state to the schedule state.
// A forward advance scans for the minimum period, then per checkpoint; one slot a cycle.
// Reset clears the slot valid bits, current time, scan index and the output valid bit.
// A stalled output holds the controller in place; no result is dropped.
// Top level of the timer table; depends on ptt_pkg, ptt_ctrl, ptt_dp and the interfaces.
module periodic_and_oneshot_timer_table
    import ptt_pkg::*;
#(
    parameter int SLOT_COUNT      = SlotCountDefault,
    parameter int MAX_CHECKPOINTS = MaxCheckpointsDefault
) (
    input logic  clk,
    input logic  rst_n,
    ptt_in_if.sink    in,
    ptt_out_if.source out
);
    ptt_cmd_t cmd;
    ptt_sts_t sts;
    logic     out_busy;

    ptt_ctrl #(.MAX_CHECKPOINTS(MAX_CHECKPOINTS)) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in.valid),
        .in_ready (in.ready),
        .out_busy (out_busy),
        .sts      (sts),
        .cmd      (cmd)
    );

    ptt_dp #(.SLOT_COUNT(SLOT_COUNT)) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .kind       (in.kind),
        .start_time (in.start_time),
        .period     (in.period),
        .end_time   (in.end_time),
        .new_time   (in.new_time),
        .cmd        (cmd),
        .sts        (sts),
        .out_ready  (out.ready),
        .out_valid  (out.valid),
        .fired_mask (out.fired_mask),
        .at_time    (out.at_time),
        .slot_index (out.slot_index),
        .status     (out.status),
        .last       (out.last),
        .out_busy   (out_busy)
    );
endmodule

// ===== rtl/ptt_checker.sv =====
// Port checker for the timer table, bound to the top level.
// Depends on ptt_pkg for status codes.
module ptt_checker
    import ptt_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] out_status,
    input logic       out_last,
    input logic [7:0] out_mask
);
    // A stalled result beat holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped while stalled");

    // Nonzero status only on the final beat.
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_status != ST_OK |-> out_last)
        else $error("error status on a non-final beat");

    // A full table result carries no firings.
    a_full_mask: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_status == ST_FULL |-> out_mask == '0)
        else $error("firings reported with table full");

    // The input never accepts beats back to back.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted back to back");
endmodule

bind periodic_and_oneshot_timer_table ptt_checker u_ptt_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in.valid),
    .in_ready   (in.ready),
    .out_valid  (out.valid),
    .out_ready  (out.ready),
    .out_status (out.status),
    .out_last   (out.last),
    .out_mask   (out.fired_mask)
);
